### rtl/latency_histogram_quantile_unit_macros.svh
// assertion helpers shared by the histogram rtl
`ifndef LATENCY_HISTOGRAM_QUANTILE_UNIT_MACROS_SVH
`define LATENCY_HISTOGRAM_QUANTILE_UNIT_MACROS_SVH

// same-cycle implication
`define LHQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lhq_pkg.sv
package lhq_pkg;

    localparam int LAT_W      = 32;
    localparam int BOUND_W    = 32;
    localparam int Q_W        = 17;
    localparam int Q_FRAC_W   = 16;
    localparam int CNT_W      = 32;
    localparam int SUM_W      = 64;
    localparam int QV_W       = 33;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_REGS   = 7;

    localparam int NUM_BOUNDS_DEF = 7;
    localparam int FIFO_DEPTH_DEF = 2;

    localparam logic [Q_FRAC_W-1:0] ROUND_UP = '1;

    localparam logic [BOUND_W-1:0] BOUND_RESET [NUM_REGS] = '{
        32'd50000, 32'd100000, 32'd250000, 32'd500000,
        32'd1000000, 32'd2500000, 32'd5000000
    };

    typedef enum logic
    {
        CMD_OBSERVE = 1'b0,
        CMD_QUERY   = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        BK_IDLE,
        BK_TGT,
        BK_SCAN
    } back_state_t;

endpackage

### rtl/latency_histogram_quantile_unit.sv
// channel   direction  handshake                 payload
// in        in         in_valid / in_stall       command, latency_us, quantile_q
// out       out        out_valid / out_stall     quantile_value, total_count, latency_sum
// cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// an item passes the front combinationally and is registered in the queue before the back sees it
// observe: handled in idle as the item is popped (bucket, count and sum updated together)
// query: multiply, target, then a scan bucket by bucket over up to NUM_BOUNDS+1 buckets;
//   a query on an empty histogram answers zero straight from the idle state
// async active-low reset: counts and sum to zero, bounds to their defaults
// out_stall holds the result register; the queue keeps taking items until full
module latency_histogram_quantile_unit #(
    parameter int NUM_BOUNDS = lhq_pkg::NUM_BOUNDS_DEF,
    parameter int FIFO_DEPTH = lhq_pkg::FIFO_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           command,
    input  logic [lhq_pkg::LAT_W-1:0]      latency_us,
    input  logic [lhq_pkg::Q_W-1:0]        quantile_q,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [lhq_pkg::QV_W-1:0]       quantile_value,
    output logic [lhq_pkg::CNT_W-1:0]      total_count,
    output logic [lhq_pkg::SUM_W-1:0]      latency_sum,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lhq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lhq_pkg::BOUND_W-1:0]    cfg_data
);

    import lhq_pkg::*;

    localparam int IDX_W   = $clog2(NUM_BOUNDS + 1);
    localparam int ENTRY_W = 1 + IDX_W + LAT_W + Q_W;

    logic               fifo_full;
    logic               fifo_empty;
    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] push_data;
    logic [ENTRY_W-1:0] pop_data;
    logic [BOUND_W-1:0] bounds [NUM_BOUNDS];

    lhq_front #(
        .NUM_BOUNDS (NUM_BOUNDS),
        .IDX_W      (IDX_W),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .latency_us (latency_us),
        .quantile_q (quantile_q),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_data  (push_data),
        .bounds     (bounds)
    );

    lhq_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (fifo_empty)
    );

    lhq_back #(
        .NUM_BOUNDS (NUM_BOUNDS),
        .IDX_W      (IDX_W),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .fifo_empty     (fifo_empty),
        .fifo_data      (pop_data),
        .pop            (pop),
        .bounds         (bounds),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .quantile_value (quantile_value),
        .total_count    (total_count),
        .latency_sum    (latency_sum)
    );

endmodule

### rtl/lhq_fifo.sv
module lhq_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    `include "latency_histogram_quantile_unit_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `LHQ_ASSERT_NOW(a_fifo_no_overflow, clk, rst_n, push, !full || pop, "fifo push while full")
    `LHQ_ASSERT_NOW(a_fifo_no_underflow, clk, rst_n, pop, !empty, "fifo pop while empty")
    `LHQ_ASSERT_NEXT(a_fifo_count_up, clk, rst_n, push && !pop,
        count_reg == $past(count_reg) + 1'b1, "fifo count did not advance")

endmodule

### rtl/lhq_front.sv
module lhq_front #(
    parameter int NUM_BOUNDS = lhq_pkg::NUM_BOUNDS_DEF,
    parameter int IDX_W      = 3,
    parameter int ENTRY_W    = 53
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           command,
    input  logic [lhq_pkg::LAT_W-1:0]      latency_us,
    input  logic [lhq_pkg::Q_W-1:0]        quantile_q,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lhq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lhq_pkg::BOUND_W-1:0]    cfg_data,
    input  logic                           fifo_full,
    output logic                           push,
    output logic [ENTRY_W-1:0]             push_data,
    output logic [lhq_pkg::BOUND_W-1:0]    bounds [NUM_BOUNDS]
);

    import lhq_pkg::*;

    typedef struct packed
    {
        logic             cmd;
        logic [IDX_W-1:0] bkt;
        logic [LAT_W-1:0] lat;
        logic [Q_W-1:0]   q;
    } entry_t;

    logic [BOUND_W-1:0] bound_reg [NUM_BOUNDS];
    logic [IDX_W-1:0]   bkt;
    entry_t             entry;

    assign cfg_ready = 1'b1;
    assign in_stall  = fifo_full;
    assign push      = in_valid && !fifo_full;
    assign bounds    = bound_reg;

    // first bucket whose bound is not below the latency
    always_comb
    begin
        bkt = IDX_W'(NUM_BOUNDS);
        for (int i = NUM_BOUNDS - 1; i >= 0; i--)
        begin
            if (latency_us <= bound_reg[i])
            begin
                bkt = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        entry.cmd = command;
        entry.bkt = bkt;
        entry.lat = latency_us;
        entry.q   = quantile_q;
    end

    assign push_data = ENTRY_W'(entry);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BOUNDS; i++)
            begin
                bound_reg[i] <= BOUND_RESET[i];
            end
        end
        else if (cfg_valid)
        begin
            for (int i = 0; i < NUM_BOUNDS; i++)
            begin
                if (cfg_index == CFG_IDX_W'(i))
                begin
                    bound_reg[i] <= cfg_data;
                end
            end
        end
    end

endmodule

### rtl/lhq_back.sv
module lhq_back #(
    parameter int NUM_BOUNDS = lhq_pkg::NUM_BOUNDS_DEF,
    parameter int IDX_W      = 3,
    parameter int ENTRY_W    = 53
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fifo_empty,
    input  logic [ENTRY_W-1:0]           fifo_data,
    output logic                         pop,
    input  logic [lhq_pkg::BOUND_W-1:0]  bounds [NUM_BOUNDS],
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [lhq_pkg::QV_W-1:0]     quantile_value,
    output logic [lhq_pkg::CNT_W-1:0]    total_count,
    output logic [lhq_pkg::SUM_W-1:0]    latency_sum
);

    import lhq_pkg::*;

    `include "latency_histogram_quantile_unit_macros.svh"

    localparam int NUM_BKT = NUM_BOUNDS + 1;
    localparam int PROD_W  = Q_W + CNT_W;
    localparam int TGT_W   = PROD_W + 1 - Q_FRAC_W;
    localparam int SEEN_W  = CNT_W + $clog2(NUM_BKT);

    typedef struct packed
    {
        logic             cmd;
        logic [IDX_W-1:0] bkt;
        logic [LAT_W-1:0] lat;
        logic [Q_W-1:0]   q;
    } entry_t;

    back_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   counts_reg [NUM_BKT];
    logic [CNT_W-1:0]   counts_next [NUM_BKT];
    logic [CNT_W-1:0]   obs_reg, obs_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [TGT_W-1:0]   target_reg, target_next;
    logic [SEEN_W-1:0]  seen_reg, seen_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [QV_W-1:0]    qv_reg, qv_next;
    logic [CNT_W-1:0]   tc_reg, tc_next;
    logic [SUM_W-1:0]   ls_reg, ls_next;

    entry_t             entry;
    logic               out_free;
    logic [SUM_W:0]     sum_add;
    logic [PROD_W:0]    round_sum;
    logic [SEEN_W-1:0]  seen_sum;
    logic               last_bkt;
    logic [QV_W-1:0]    answer;

    assign entry          = entry_t'(fifo_data);
    assign out_free       = !out_valid_reg || !out_stall;
    assign out_valid      = out_valid_reg;
    assign quantile_value = qv_reg;
    assign total_count    = tc_reg;
    assign latency_sum    = ls_reg;

    assign sum_add   = {1'b0, sum_reg} + (SUM_W + 1)'(entry.lat);
    assign round_sum = {1'b0, prod_reg} + (PROD_W + 1)'(ROUND_UP);
    assign seen_sum  = seen_reg + SEEN_W'(counts_reg[idx_reg]);
    assign last_bkt  = (idx_reg == IDX_W'(NUM_BOUNDS));

    // bound of the current bucket, or twice the last bound for overflow
    always_comb
    begin
        answer = {bounds[NUM_BOUNDS - 1], 1'b0};
        for (int i = 0; i < NUM_BOUNDS; i++)
        begin
            if (idx_reg == IDX_W'(i))
            begin
                answer = QV_W'(bounds[i]);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        counts_next    = counts_reg;
        obs_next       = obs_reg;
        sum_next       = sum_reg;
        prod_next      = prod_reg;
        target_next    = target_reg;
        seen_next      = seen_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        qv_next        = qv_reg;
        tc_next        = tc_reg;
        ls_next        = ls_reg;
        pop            = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!fifo_empty && out_free)
                begin
                    pop = 1'b1;
                    if (entry.cmd == CMD_OBSERVE)
                    begin
                        if (counts_reg[entry.bkt] != '1)
                        begin
                            counts_next[entry.bkt] = counts_reg[entry.bkt] + 1'b1;
                        end
                        if (obs_reg != '1)
                        begin
                            obs_next = obs_reg + 1'b1;
                        end
                        sum_next       = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                        out_valid_next = 1'b1;
                        qv_next        = '0;
                        tc_next        = obs_next;
                        ls_next        = sum_next;
                    end
                    else if (obs_reg == '0)
                    begin
                        out_valid_next = 1'b1;
                        qv_next        = '0;
                        tc_next        = obs_reg;
                        ls_next        = sum_reg;
                    end
                    else
                    begin
                        prod_next  = PROD_W'(entry.q) * PROD_W'(obs_reg);
                        state_next = BK_TGT;
                    end
                end
            end
            BK_TGT:
            begin
                target_next = round_sum[PROD_W:Q_FRAC_W];
                seen_next   = '0;
                idx_next    = '0;
                state_next  = BK_SCAN;
            end
            BK_SCAN:
            begin
                if (seen_sum >= SEEN_W'(target_reg) || last_bkt)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        qv_next        = answer;
                        tc_next        = obs_reg;
                        ls_next        = sum_reg;
                        state_next     = BK_IDLE;
                    end
                end
                else
                begin
                    seen_next = seen_sum;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            obs_reg       <= '0;
            sum_reg       <= '0;
            for (int i = 0; i < NUM_BKT; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            obs_reg       <= obs_next;
            sum_reg       <= sum_next;
            counts_reg    <= counts_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= prod_next;
        target_reg <= target_next;
        seen_reg   <= seen_next;
        idx_reg    <= idx_next;
        qv_reg     <= qv_next;
        tc_reg     <= tc_next;
        ls_reg     <= ls_next;
    end

    `LHQ_ASSERT_NOW(a_back_pop_idle, clk, rst_n, pop, state_reg == BK_IDLE,
        "pop outside idle")
    `LHQ_ASSERT_NOW(a_back_idx_range, clk, rst_n, state_reg == BK_SCAN,
        idx_reg <= IDX_W'(NUM_BOUNDS), "scan index past overflow bucket")
    `LHQ_ASSERT_NEXT(a_back_count_mono, clk, rst_n, 1'b1,
        obs_reg >= $past(obs_reg), "observation count went down")

endmodule

### tb/latency_histogram_quantile_unit_test.sv
`timescale 1ns / 100ps

module latency_histogram_quantile_unit_test;

    import lhq_pkg::*;

    localparam int HIST_BOUNDS    = NUM_BOUNDS_DEF;
    localparam int HIST_BUCKETS   = HIST_BOUNDS + 1;
    localparam int SETTLE_CYCLES  = 16;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PER_SET = 160;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    typedef enum int
    {
        SHAPE_TIGHT,
        SHAPE_WIDE,
        SHAPE_ZERO,
        SHAPE_FULL,
        SHAPE_SHUFFLED,
        SHAPE_FLAT
    } bound_shape_t;

    typedef struct packed
    {
        logic [QV_W-1:0]  quantile;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
    } hist_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    cmd_t                 command = CMD_OBSERVE;
    logic [LAT_W-1:0]     latency_us = '0;
    logic [Q_W-1:0]       quantile_q = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [QV_W-1:0]      quantile_value;
    logic [CNT_W-1:0]     total_count;
    logic [SUM_W-1:0]     latency_sum;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [BOUND_W-1:0]   cfg_data = '0;

    // histogram predictor state
    logic [BOUND_W-1:0] model_bounds [NUM_REGS];
    logic [CNT_W-1:0]   model_buckets [HIST_BUCKETS];
    logic [CNT_W-1:0]   model_count = '0;
    logic [SUM_W-1:0]   model_sum = '0;

    hist_result_t pending_results [$];
    int           mismatches = 0;
    int           quiet_cycles = 0;
    bit           sender_gaps = 1'b0;
    bit           receiver_gaps = 1'b0;
    bit           hold_request = 1'b0;

    latency_histogram_quantile_unit #(
        .NUM_BOUNDS (HIST_BOUNDS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .latency_us     (latency_us),
        .quantile_q     (quantile_q),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .quantile_value (quantile_value),
        .total_count    (total_count),
        .latency_sum    (latency_sum),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic void record_latency(input logic [LAT_W-1:0] lat);
        int idx;
        logic [SUM_W:0] wide;
        idx = 0;
        while (idx < HIST_BOUNDS && lat > model_bounds[idx])
            idx++;
        if (model_buckets[idx] != '1)
            model_buckets[idx] = model_buckets[idx] + 1'b1;
        if (model_count != '1)
            model_count = model_count + 1'b1;
        wide = {1'b0, model_sum} + {33'd0, lat};
        model_sum = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
    endfunction

    function automatic logic [QV_W-1:0] answer_query(input logic [Q_W-1:0] q);
        logic [63:0]     q_wide;
        logic [63:0]     total;
        logic [63:0]     target;
        logic [63:0]     seen;
        logic [QV_W-1:0] overflow_value;
        int              i;
        overflow_value = {model_bounds[HIST_BOUNDS-1], 1'b0};
        if (model_count == '0)
            return '0;
        q_wide = {47'd0, q};
        total = {32'd0, model_count};
        target = (q_wide * total + {48'd0, ROUND_UP}) >> Q_FRAC_W;
        seen = '0;
        for (i = 0; i <= HIST_BOUNDS; i++)
        begin
            seen = seen + {32'd0, model_buckets[i]};
            if (seen >= target)
                return (i < HIST_BOUNDS) ? {1'b0, model_bounds[i]} : overflow_value;
        end
        return overflow_value;
    endfunction

    function automatic void queue_result(input hist_result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    always @(posedge clk)
    begin : predict_results
        hist_result_t due;
        if (rst_n && in_valid && !in_stall)
        begin
            due.quantile = '0;
            if (command == CMD_OBSERVE)
                record_latency(latency_us);
            else
                due.quantile = answer_query(quantile_q);
            due.count = model_count;
            due.sum = model_sum;
            queue_result(due);
        end
    end

    always @(posedge clk)
    begin : track_bounds
        if (rst_n && cfg_valid && cfg_ready && cfg_index < NUM_REGS)
            model_bounds[cfg_index] = cfg_data;
    end

    always @(posedge clk)
    begin : check_results
        hist_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result: value %0d count %0d sum %0d",
                             quantile_value, total_count, latency_sum);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (quantile_value !== want.quantile || total_count !== want.count ||
                    latency_sum !== want.sum)
                begin
                    if (mismatches < 10)
                        $display("mismatch: value %0d/%0d count %0d/%0d sum %0d/%0d",
                                 want.quantile, quantile_value, want.count, total_count,
                                 want.sum, latency_sum);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("latency_histogram_quantile_unit_test: FAIL");
            $finish;
        end
    end

    initial
    begin : receiver
        int span;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
                hold_request = 1'b0;
            end
            else if (receiver_gaps && $urandom_range(0, 7) == 0)
            begin
                span = $urandom_range(1, 13);
                out_stall <= 1'b1;
                repeat (span) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input cmd_t cmd, input logic [LAT_W-1:0] lat,
                             input logic [Q_W-1:0] q);
        int gap;
        if (sender_gaps && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        latency_us <= lat;
        quantile_q <= q;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic observe(input logic [LAT_W-1:0] lat);
        send_item(CMD_OBSERVE, lat, Q_W'($urandom));
    endtask

    task automatic ask(input logic [Q_W-1:0] q);
        send_item(CMD_QUERY, $urandom, q);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_bounds(input logic [BOUND_W-1:0] vals [NUM_REGS]);
        int i;
        for (i = 0; i <= NUM_REGS; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= (i < NUM_REGS) ? i[CFG_IDX_W-1:0] : CFG_UNUSED_INDEX;
            cfg_data <= (i < NUM_REGS) ? vals[i] : $urandom;
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic make_bounds(input bound_shape_t shape,
                               output logic [BOUND_W-1:0] vals [NUM_REGS]);
        logic [63:0] level;
        int i;
        level = (shape == SHAPE_TIGHT) ? 64'($urandom_range(0, 20)) :
                                         64'($urandom_range(0, 1000));
        for (i = 0; i < NUM_REGS; i++)
        begin
            case (shape)
                SHAPE_TIGHT:    vals[i] = level[31:0];
                SHAPE_WIDE:     vals[i] = (level > 64'hFFFF_FFFF) ? '1 : level[31:0];
                SHAPE_ZERO:     vals[i] = '0;
                SHAPE_FULL:     vals[i] = '1;
                SHAPE_SHUFFLED: vals[i] = $urandom;
                default:        vals[i] = 32'd777;
            endcase
            if (shape == SHAPE_TIGHT)
                level = level + 64'($urandom_range(0, 40));
            else
                level = level + 64'($urandom_range(1, 600000000));
        end
    endtask

    function automatic logic [LAT_W-1:0] pick_latency();
        int k;
        k = $urandom_range(0, HIST_BOUNDS - 1);
        case ($urandom_range(0, 6))
            0:       return model_bounds[k];
            1:       return model_bounds[k] + 1'b1;
            2:       return model_bounds[k] - 1'b1;
            3:       return $urandom;
            4:       return ($urandom_range(0, 1) == 0) ? '0 : '1;
            default: return $urandom_range(0, model_bounds[HIST_BOUNDS-1]);
        endcase
    endfunction

    function automatic logic [Q_W-1:0] pick_fraction();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return 17'd65536;
            2:       return Q_W'($urandom_range(65537, 131071));
            3:       return Q_W'($urandom_range(0, 131071));
            4:       return ($urandom_range(0, 1) == 0) ? 17'd62259 : 17'd64881;
            default: return Q_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic send_random_item();
        if ($urandom_range(0, 99) < 60)
            observe(pick_latency());
        else
            ask(pick_fraction());
    endtask

    task automatic test_default_bounds();
        ask(17'd0);
        ask(17'd65536);
        ask(17'd131071);
        observe(32'd0);
        observe(32'd50000);
        observe(32'd50001);
        observe(32'd5000001);
        observe(32'hFFFF_FFFF);
        ask(17'd0);
        ask(17'd1);
        ask(17'd65536);
        ask(17'd65537);
        ask(17'd131071);
        wait_drained();
    endtask

    task automatic test_bound_extremes();
        logic [BOUND_W-1:0] vals [NUM_REGS];
        int i;
        make_bounds(SHAPE_ZERO, vals);
        program_bounds(vals);
        observe(32'd1);
        ask(17'd32768);
        wait_drained();
        make_bounds(SHAPE_FULL, vals);
        program_bounds(vals);
        observe(32'hFFFF_FFFF);
        ask(17'd65536);
        ask(17'd131071);
        wait_drained();
        // descending bounds
        for (i = 0; i < NUM_REGS; i++)
            vals[i] = 32'd7000 - 32'd1000 * i;
        program_bounds(vals);
        observe(32'd6500);
        observe(32'd7001);
        observe(32'd500);
        ask(17'd16384);
        ask(17'd65536);
        wait_drained();
    endtask

    task automatic test_random_settings();
        logic [BOUND_W-1:0] vals [NUM_REGS];
        int s;
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
        for (s = SHAPE_TIGHT; s <= SHAPE_FLAT; s++)
        begin
            make_bounds(bound_shape_t'(s), vals);
            program_bounds(vals);
            repeat (RANDOM_PER_SET) send_random_item();
            wait_drained();
        end
    endtask

    task automatic test_output_backpressure();
        logic [BOUND_W-1:0] vals [NUM_REGS];
        make_bounds(SHAPE_TIGHT, vals);
        program_bounds(vals);
        hold_request = 1'b1;
        repeat (40) send_random_item();
        wait_drained();
    endtask

    task automatic test_sender_pause();
        repeat (20) send_random_item();
        wait_drained();
        repeat (20) send_random_item();
        wait_drained();
    endtask

    task automatic test_back_to_back();
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        program_bounds(BOUND_RESET);
        repeat (100) send_random_item();
        wait_drained();
    endtask

    initial
    begin : run
        int i;
        model_bounds = BOUND_RESET;
        for (i = 0; i < HIST_BUCKETS; i++)
            model_buckets[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_bounds();
        test_bound_extremes();
        test_random_settings();
        test_output_backpressure();
        test_sender_pause();
        test_back_to_back();
        if (pending_results.size() != 0)
            $display("%0d results never arrived", pending_results.size());
        if (mismatches == 0 && pending_results.size() == 0)
            $display("latency_histogram_quantile_unit_test: PASS");
        else
            $display("latency_histogram_quantile_unit_test: FAIL");
        $finish;
    end

endmodule
